// ===== hdl/twe_pkg.sv =====
// Shared constants and types of the timestamp wrap extender.
package twe_pkg;

    localparam int SECTIONS = 16;
    localparam int SEC_W    = 4;
    localparam int RAW_W    = 32;
    localparam int TICK_W   = 63;
    localparam int HI_W     = TICK_W - RAW_W;
    localparam int SECS_W   = 32;
    localparam int TPS_W    = 32;
    localparam int EL_W     = SECS_W + TPS_W;
    localparam int Q_W      = EL_W - RAW_W;
    localparam int OUT_W    = TICK_W + 1;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);

    typedef struct packed {
        logic [TICK_W-1:0] anchor;
        logic [TICK_W-1:0] last;
    } t_entry;

    typedef struct packed {
        logic has_prev;
        logic seconds_ok;
    } t_ext_ctl;

endpackage

// ===== hdl/twe_extend.sv =====
// Tick extension: wrap count from raw compare or from elapsed seconds, then unwrap.
module twe_extend import twe_pkg::*; (
    input  t_ext_ctl          i_ctl,
    input  logic [TICK_W-1:0] i_prev,
    input  logic [RAW_W-1:0]  i_raw,
    input  logic [EL_W-1:0]   i_elapsed,
    output logic [TICK_W-1:0] o_ext
);

    localparam logic [RAW_W+2:0] HALF = (RAW_W+3)'(1) << (RAW_W - 1);

    logic [RAW_W-1:0]  pr;
    logic [RAW_W-1:0]  lo;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    q_dec;
    logic [Q_W-1:0]    q_inc;
    logic [HI_W-1:0]   hi;
    logic [HI_W-1:0]   w;
    logic [HI_W-1:0]   w_sec;
    logic [RAW_W+2:0]  s;
    logic              neg;
    logic [1:0]        c;

    always_comb begin
        pr    = i_prev[RAW_W-1:0];
        hi    = i_prev[TICK_W-1:RAW_W];
        lo    = i_elapsed[RAW_W-1:0];
        q     = i_elapsed[EL_W-1:RAW_W];
        s     = {3'b000, lo} + {3'b000, pr} - {3'b000, i_raw} + HALF;
        neg   = s[RAW_W+2];
        c     = s[RAW_W+1:RAW_W];
        q_dec = q - Q_W'(1);
        q_inc = q + Q_W'(c);
        if (neg) begin
            w_sec = (q == '0) ? '0 : q_dec[HI_W-1:0];
        end else begin
            w_sec = q_inc[HI_W-1:0];
        end
        if (i_ctl.seconds_ok) begin
            w = w_sec;
        end else begin
            w = HI_W'(i_raw < pr);
        end
        if (i_ctl.has_prev) begin
            o_ext = {hi + w, i_raw};
        end else begin
            o_ext = {{HI_W{1'b0}}, i_raw};
        end
    end

endmodule

// ===== hdl/timestamp_wrap_extender.sv =====
// Timestamp wrap extender: one word per cycle, three-stage pipeline around a
// 16-entry synchronous section memory. Stage 1 reads the section entry and
// takes the seconds difference, stage 2 multiplies it by ticks_per_second,
// stage 3 extends the tick, writes the entry back and loads the output
// register. The sustained rate is one word per cycle while the output is not
// stalled, set by the single read and write port of the section memory, with
// writes forwarded to younger words of the same section. Output stalls back up
// through the stages.
module timestamp_wrap_extender import twe_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TPS_W-1:0]         i_cfg_ticks_per_second,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SEC_W-1:0]         i_section,
    input  logic [31:0]              i_raw_tick,
    input  logic                     i_raw_valid,
    input  logic [SECS_W-1:0]        i_unix_seconds,
    input  logic                     i_end_of_event,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SEC_W-1:0]         o_section_out,
    output logic [TICK_W-1:0]        o_extended_tick,
    output logic                     o_tick_valid,
    output logic signed [OUT_W-1:0]  o_elapsed_ticks,
    output logic [SECS_W-1:0]        o_anchor_seconds,
    output logic                     o_time_valid
);

    t_entry mem [SECTIONS];

    logic [TPS_W-1:0]  r_tps;
    logic [SECS_W-1:0] r_last_s;
    logic [SECS_W-1:0] r_anchor_s;
    logic              r_anchored;
    logic [SECTIONS-1:0] r_ltv;
    logic [SECTIONS-1:0] r_av;

    logic              r_s1_v;
    logic [SEC_W-1:0]  r_s1_sec;
    logic [RAW_W-1:0]  r_s1_raw;
    logic              r_s1_rv;
    logic [SECS_W-1:0] r_s1_diff;
    logic              r_s1_avail;
    logic              r_s1_anch;
    logic [SECS_W-1:0] r_s1_asec;
    logic              r_s1_fwd;
    t_entry            r_s1_fwd_data;
    t_entry            r_mem_q;

    logic              r_s2_v;
    logic [SEC_W-1:0]  r_s2_sec;
    logic [RAW_W-1:0]  r_s2_raw;
    logic              r_s2_rv;
    logic [EL_W-1:0]   r_s2_el;
    logic              r_s2_avail;
    logic              r_s2_anch;
    logic [SECS_W-1:0] r_s2_asec;
    t_entry            r_s2_prev;

    logic              r_out_v;
    logic [SEC_W-1:0]  r_out_sec;
    logic [TICK_W-1:0] r_out_ext;
    logic [TICK_W-1:0] r_out_anc;
    logic              r_out_tv;
    logic              r_out_timev;
    logic [SECS_W-1:0] r_out_asec;

    logic              out_free;
    logic              s2_go;
    logic              s2_free;
    logic              s1_go;
    logic              in_acc;
    logic              avail;
    logic              wr_en;
    logic              hit_in;
    logic              hit_s1;
    t_entry            s1_prev;
    t_entry            wdata;
    t_ext_ctl          ext_ctl;
    logic [TICK_W-1:0] ext_raw;
    logic [TICK_W-1:0] ext;
    logic [TICK_W-1:0] anc_new;
    logic              timev;
    logic [OUT_W-1:0]  diff_out;

    assign out_free = !r_out_v || i_ready;
    assign s2_go    = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_go    = r_s1_v && s2_free;
    assign o_ready  = !r_s1_v || s2_free;
    assign in_acc   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign avail = (i_unix_seconds != '0) && (r_last_s != '0) && (i_unix_seconds >= r_last_s);

    assign s1_prev = r_s1_fwd ? r_s1_fwd_data : r_mem_q;

    assign ext_ctl.has_prev   = r_ltv[r_s2_sec];
    assign ext_ctl.seconds_ok = r_s2_avail;

    twe_extend u_extend (
        .i_ctl     (ext_ctl),
        .i_prev    (r_s2_prev.last),
        .i_raw     (r_s2_raw),
        .i_elapsed (r_s2_el),
        .o_ext     (ext_raw)
    );

    assign ext     = r_s2_rv ? ext_raw : '0;
    assign anc_new = r_s2_anch ? r_s2_prev.anchor : ext;
    assign timev   = r_s2_rv && (r_av[r_s2_sec] || !r_s2_anch);
    assign wr_en   = s2_go && r_s2_rv;
    assign wdata.anchor = anc_new;
    assign wdata.last   = ext;
    assign hit_in  = wr_en && (r_s2_sec == i_section);
    assign hit_s1  = wr_en && (r_s2_sec == r_s1_sec);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s2_sec] <= wdata;
        end
        if (in_acc) begin
            r_mem_q <= mem[i_section];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps      <= TPS_RESET;
            r_last_s   <= '0;
            r_anchor_s <= '0;
            r_anchored <= 1'b0;
            r_ltv      <= '0;
            r_av       <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tps <= i_cfg_ticks_per_second;
            end
            if (in_acc && i_end_of_event) begin
                if (i_unix_seconds != '0) begin
                    r_last_s <= i_unix_seconds;
                end
                if (!r_anchored) begin
                    r_anchor_s <= i_unix_seconds;
                    r_anchored <= 1'b1;
                end
            end
            if (wr_en) begin
                r_ltv[r_s2_sec] <= 1'b1;
                if (!r_s2_anch) begin
                    r_av[r_s2_sec] <= 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (s2_go) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sec      <= i_section;
            r_s1_raw      <= i_raw_tick[RAW_W-1:0];
            r_s1_rv       <= i_raw_valid;
            r_s1_diff     <= i_unix_seconds - r_last_s;
            r_s1_avail    <= avail;
            r_s1_anch     <= r_anchored;
            r_s1_asec     <= r_anchored ? r_anchor_s : i_unix_seconds;
            r_s1_fwd      <= hit_in;
            r_s1_fwd_data <= wdata;
        end else if (hit_s1) begin
            r_s1_fwd      <= 1'b1;
            r_s1_fwd_data <= wdata;
        end
        if (s1_go) begin
            r_s2_sec   <= r_s1_sec;
            r_s2_raw   <= r_s1_raw;
            r_s2_rv    <= r_s1_rv;
            r_s2_el    <= r_s1_diff * r_tps;
            r_s2_avail <= r_s1_avail;
            r_s2_anch  <= r_s1_anch;
            r_s2_asec  <= r_s1_asec;
            r_s2_prev  <= hit_s1 ? wdata : s1_prev;
        end
        if (s2_go) begin
            r_out_sec   <= r_s2_sec;
            r_out_ext   <= ext;
            r_out_anc   <= anc_new;
            r_out_tv    <= r_s2_rv;
            r_out_timev <= timev;
            r_out_asec  <= r_s2_asec;
        end
    end

    assign diff_out = {1'b0, r_out_ext} - {1'b0, r_out_anc};

    assign o_valid          = r_out_v;
    assign o_section_out    = r_out_sec;
    assign o_extended_tick  = r_out_ext;
    assign o_tick_valid     = r_out_tv;
    assign o_elapsed_ticks  = r_out_timev ? $signed(diff_out) : '0;
    assign o_anchor_seconds = r_out_asec;
    assign o_time_valid     = r_out_timev;

endmodule

// ===== hdl/twe_checker.sv =====
// Port-level checks of the timestamp wrap extender, bound to the top level.
module twe_checker import twe_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [TICK_W-1:0]       o_extended_tick,
    input logic                    o_tick_valid,
    input logic signed [OUT_W-1:0] o_elapsed_ticks,
    input logic                    o_time_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_extended_tick))
        else $error("output word changed while stalled");

    a_time_needs_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_time_valid |-> o_tick_valid)
        else $error("time valid without tick valid");

    a_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tick_valid |-> o_extended_tick == '0)
        else $error("extended tick nonzero without tick valid");

    a_elapsed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_time_valid |-> o_elapsed_ticks == '0)
        else $error("elapsed ticks nonzero without time valid");

endmodule

bind timestamp_wrap_extender twe_checker u_twe_checker (.*);
